// ----- hdl/lcr_pkg.sv -----
// Shared types and constants for the load-cell serial reader.
// Used by lcr_ctrl, lcr_scale and load_cell_adc_serial_reader_core.
package lcr_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 24;

  localparam int PULSE_W  = 2;
  localparam int HALF_W   = 10;
  localparam int COEF_W   = 32;
  localparam int WEIGHT_W = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_SHIFT = 16;

  // Register reset values
  localparam logic [PULSE_W-1:0]         EXTRA_PULSES_RST = 2'd1;
  localparam logic [HALF_W-1:0]          HALF_PERIOD_RST  = 10'd10;
  localparam logic signed [COEF_W-1:0]   SCALE_COEF_RST   = 32'sd103590;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_OFS_RST   = 32'sd0;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7fff_ffff;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTRA_PULSES = 3'd0,
    REG_HALF_PERIOD  = 3'd1,
    REG_SCALE_COEF   = 3'd2,
    REG_WEIGHT_OFS   = 3'd3,
    REG_POWER_DOWN   = 3'd4
  } cfg_reg_t;

  // Load strobes for the two arithmetic stages
  typedef struct packed {
    logic load_mid;
    logic load_out;
  } pipe_ctl_t;

endpackage

// ----- hdl/lcr_ctrl.sv -----
// Tick sequencer: converter clock generation and serial bit capture.
// Depends on lcr_pkg. Produces the per-tick result into the first pipe stage.
module lcr_ctrl #(
  parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          data_pin,
  input  logic [lcr_pkg::PULSE_W-1:0]   extra_pulses,
  input  logic [lcr_pkg::HALF_W-1:0]    half_period_ticks,
  input  logic                          power_down,
  output logic                          tick_clock,
  output logic                          tick_valid,
  output logic [SAMPLE_BITS-1:0]        tick_raw
);
  import lcr_pkg::*;

  localparam int BC_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [BC_W-1:0] BC_LAST = BC_W'(SAMPLE_BITS);
  localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHIFT = 2'd1,
    PH_GAIN  = 2'd2
  } phase_t;

  phase_t                 phase, phase_next;
  logic [BC_W-1:0]        bit_count, bit_count_next, bit_count_inc;
  logic [PULSE_W:0]       pulse_inc;
  logic [PULSE_W-1:0]     pulse_count, pulse_count_next;
  logic [HALF_W-1:0]      half_timer, half_timer_next, timer_inc;
  logic                   clock_level, clock_level_next;
  logic [SAMPLE_BITS-1:0] shift_data, shift_data_next;
  logic [HALF_W-1:0]      hp;
  logic [PULSE_W:0]       np;
  logic                   fire;

  assign hp = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
  assign np = (extra_pulses == '0) ? (PULSE_W+1)'(1) : {1'b0, extra_pulses};
  assign timer_inc     = half_timer + 1'b1;
  assign bit_count_inc = bit_count + 1'b1;
  assign pulse_inc     = {1'b0, pulse_count} + 1'b1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    pulse_count_next = pulse_count;
    half_timer_next  = half_timer;
    clock_level_next = clock_level;
    shift_data_next  = shift_data;
    fire             = 1'b0;
    if (power_down) begin
      phase_next       = PH_IDLE;
      bit_count_next   = '0;
      pulse_count_next = '0;
      half_timer_next  = '0;
      clock_level_next = 1'b1;
    end else begin
      case (phase)
        PH_IDLE: begin
          clock_level_next = 1'b0;
          if (!data_pin) begin
            phase_next       = PH_SHIFT;
            bit_count_next   = '0;
            pulse_count_next = '0;
            half_timer_next  = '0;
            shift_data_next  = '0;
            clock_level_next = 1'b1;
          end
        end
        PH_SHIFT, PH_GAIN: begin
          half_timer_next = timer_inc;
          if (timer_inc >= hp) begin
            half_timer_next = '0;
            if (clock_level) begin
              clock_level_next = 1'b0;
            end else if (phase == PH_SHIFT) begin
              // sample at the end of the low half
              shift_data_next  = {shift_data[SAMPLE_BITS-2:0], data_pin};
              bit_count_next   = bit_count_inc;
              if (bit_count_inc >= BC_LAST) begin
                phase_next       = PH_GAIN;
                pulse_count_next = '0;
              end
              clock_level_next = 1'b1;
            end else begin
              pulse_count_next = pulse_inc[PULSE_W-1:0];
              if (pulse_inc >= np) begin
                fire             = 1'b1;
                phase_next       = PH_IDLE;
                bit_count_next   = '0;
                pulse_count_next = '0;
                clock_level_next = 1'b0;
              end else begin
                clock_level_next = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      pulse_count <= '0;
      half_timer  <= '0;
      clock_level <= 1'b0;
      shift_data  <= '0;
      tick_valid  <= 1'b0;
      tick_clock  <= 1'b0;
      tick_raw    <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      pulse_count <= pulse_count_next;
      half_timer  <= half_timer_next;
      clock_level <= clock_level_next;
      shift_data  <= shift_data_next;
      tick_clock  <= clock_level_next;
      tick_valid  <= fire;
      tick_raw    <= fire ? (shift_data ^ SIGN_FLIP) : '0;
    end
  end

endmodule

// ----- hdl/lcr_scale.sv -----
// Weight scaling pipe: signed multiply stage, then offset add and saturate.
// Depends on lcr_pkg (widths, limits, pipe_ctl_t).
module lcr_scale #(
  parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  lcr_pkg::pipe_ctl_t                   ctl,
  input  logic                                 tick_clock,
  input  logic                                 tick_valid,
  input  logic [SAMPLE_BITS-1:0]               tick_raw,
  input  logic signed [lcr_pkg::COEF_W-1:0]    scale_coef,
  input  logic signed [lcr_pkg::WEIGHT_W-1:0]  weight_offset,
  output logic                                 clock_pin,
  output logic                                 sample_valid,
  output logic [SAMPLE_BITS-1:0]               raw_code,
  output logic signed [lcr_pkg::WEIGHT_W-1:0]  weight
);
  import lcr_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;

  logic                     mid_clock;
  logic                     mid_valid;
  logic [SAMPLE_BITS-1:0]   mid_raw;
  logic signed [PROD_W-1:0] mid_prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] quot;
  logic signed [SUM_W-1:0]  sum;
  logic signed [WEIGHT_W-1:0] weight_next;

  // raw is unsigned: zero-extend one bit so the product is signed
  assign prod_next = PROD_W'(scale_coef) * PROD_W'($signed({1'b0, tick_raw}));

  // arithmetic shift gives floor of the division, for either sign
  assign quot = mid_prod >>> FRAC_SHIFT;
  assign sum  = SUM_W'(quot) + SUM_W'(weight_offset);

  always_comb begin
    if (!mid_valid) begin
      weight_next = '0;
    end else if (sum > SUM_W'(WEIGHT_MAX)) begin
      weight_next = WEIGHT_MAX;
    end else if (sum < SUM_W'(WEIGHT_MIN)) begin
      weight_next = WEIGHT_MIN;
    end else begin
      weight_next = sum[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_mid) begin
      mid_clock <= tick_clock;
      mid_valid <= tick_valid;
      mid_raw   <= tick_raw;
      mid_prod  <= prod_next;
    end
    if (ctl.load_out) begin
      clock_pin    <= mid_clock;
      sample_valid <= mid_valid;
      raw_code     <= mid_raw;
      weight       <= weight_next;
    end
  end

endmodule

// ----- hdl/load_cell_adc_serial_reader_core.sv -----
// Top level of the load-cell converter serial reader.
// Depends on lcr_pkg, lcr_ctrl and lcr_scale.
//
//  channel | signals                         | transaction carries
//  --------+---------------------------------+--------------------------------------
//  in      | in_valid, in_stall              | data_pin (one time tick)
//  out     | out_valid, out_stall            | clock_pin, sample_valid, raw_code,
//          |                                 | weight (one result per tick)
//  cfg     | cfg_write, cfg_index, cfg_data  | register write, no handshake
//
// One tick is taken per cycle, back to back, while in_stall is low. An accepted
// tick sits in the sequencer stage, then moves on to the multiply stage and
// from there reaches the result register (offset/saturate).
// Synchronous active-high rst returns the sequencer to idle, empties the pipe
// and loads register defaults.
// out_stall holds the result register; an earlier stage still moves into an
// empty slot, so in_stall rises only when all three stages hold a
// transaction and out_stall is high.
module load_cell_adc_serial_reader_core #(
  parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 data_pin,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 clock_pin,
  output logic                                 sample_valid,
  output logic [SAMPLE_BITS-1:0]               raw_code,
  output logic signed [lcr_pkg::WEIGHT_W-1:0]  weight,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcr_pkg::CFG_W-1:0]            cfg_data
);
  import lcr_pkg::*;

  // configuration registers
  logic [PULSE_W-1:0]         extra_pulses;
  logic [HALF_W-1:0]          half_period_ticks;
  logic signed [COEF_W-1:0]   scale_coef;
  logic signed [WEIGHT_W-1:0] weight_offset;
  logic                       power_down;

  // stage occupancy
  logic      v1, v2, v3;
  logic      rdy1, rdy2, rdy3;
  logic      accept;
  pipe_ctl_t ctl;

  logic                   tick_clock;
  logic                   tick_valid;
  logic [SAMPLE_BITS-1:0] tick_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_pulses      <= EXTRA_PULSES_RST;
      half_period_ticks <= HALF_PERIOD_RST;
      scale_coef        <= SCALE_COEF_RST;
      weight_offset     <= WEIGHT_OFS_RST;
      power_down        <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXTRA_PULSES: extra_pulses      <= cfg_data[PULSE_W-1:0];
        REG_HALF_PERIOD:  half_period_ticks <= cfg_data[HALF_W-1:0];
        REG_SCALE_COEF:   scale_coef        <= $signed(cfg_data[COEF_W-1:0]);
        REG_WEIGHT_OFS:   weight_offset     <= $signed(cfg_data[WEIGHT_W-1:0]);
        REG_POWER_DOWN:   power_down        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Ready ripples back from the result register: a stage can load when it
  // is empty or when its contents move on this cycle.
  assign rdy3     = !v3 || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  assign ctl.load_mid = v1 && rdy2;
  assign ctl.load_out = v2 && rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (rdy2) begin
        v1 <= 1'b0;
      end
      if (ctl.load_mid) begin
        v2 <= 1'b1;
      end else if (rdy3) begin
        v2 <= 1'b0;
      end
      if (ctl.load_out) begin
        v3 <= 1'b1;
      end else if (!out_stall) begin
        v3 <= 1'b0;
      end
    end
  end

  assign out_valid = v3;

  // Sequencer: the converter clock level and bit capture advance once per
  // accepted tick, so stalls stretch the serial timing, never corrupt it.
  lcr_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_pin         (data_pin),
    .extra_pulses     (extra_pulses),
    .half_period_ticks(half_period_ticks),
    .power_down       (power_down),
    .tick_clock       (tick_clock),
    .tick_valid       (tick_valid),
    .tick_raw         (tick_raw)
  );

  // Weight = floor(coef * raw / 2^16) + offset, saturated to 32 bits;
  // zero on ticks without a finished conversion.
  lcr_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk          (clk),
    .ctl          (ctl),
    .tick_clock   (tick_clock),
    .tick_valid   (tick_valid),
    .tick_raw     (tick_raw),
    .scale_coef   (scale_coef),
    .weight_offset(weight_offset),
    .clock_pin    (clock_pin),
    .sample_valid (sample_valid),
    .raw_code     (raw_code),
    .weight       (weight)
  );

endmodule
